// ===== rtl/radix_scatter_write_combining_macros.svh =====
// Assertion macros for the radix scatter write-combining block.
// Included by the top level; no other dependencies.
`ifndef RADIX_SCATTER_WRITE_COMBINING_MACROS_SVH
`define RADIX_SCATTER_WRITE_COMBINING_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSWC_ASSERT_IMPL(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSWC_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rswc_pkg.sv =====
// Shared types and constants for the radix scatter write-combining block.
// No dependencies.
package rswc_pkg;

  localparam int KEY_W       = 32;
  localparam int BKT_W_MAX   = 16;
  localparam int CNT_W_MAX   = 4;
  localparam int CFG_W       = 5;
  localparam int IDX_W       = 12;

  // Register indexes of the configuration port
  localparam logic CFG_DIGIT_SHIFT = 1'b0;
  localparam logic CFG_BASE_PHASE  = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_KEY    = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_IGNORE = 2'd3
  } cmd_e;

  // One classified command as it waits in the queue
  typedef struct packed {
    cmd_e                   cmd;
    logic [BKT_W_MAX-1:0]   bucket;
    logic [KEY_W-1:0]       data;    // key for scatter, start offset for load
    logic [CNT_W_MAX-1:0]   head;    // head words of the start offset (load)
  } entry_t;

  // Status of the back end toward the top level
  typedef struct packed {
    logic clearing;
    logic idle;
  } back_stat_t;

endpackage

// ===== rtl/rswc_head.sv =====
// Head-word calculator: words left from an offset to the next line boundary.
// Depends on rswc_pkg.
module rswc_head #(
  parameter int LINE_WORDS = 16
) (
  input  logic [rswc_pkg::KEY_W-1:0]     offset_i,
  input  logic [3:0]                     phase_i,
  output logic [rswc_pkg::CNT_W_MAX-1:0] head_o
);
  import rswc_pkg::*;

  // 16^k mod LINE_WORDS, one weight per nibble
  localparam int W0 = 1 % LINE_WORDS;
  localparam int W1 = (W0 * 16) % LINE_WORDS;
  localparam int W2 = (W1 * 16) % LINE_WORDS;
  localparam int W3 = (W2 * 16) % LINE_WORDS;
  localparam int W4 = (W3 * 16) % LINE_WORDS;
  localparam int W5 = (W4 * 16) % LINE_WORDS;
  localparam int W6 = (W5 * 16) % LINE_WORDS;
  localparam int W7 = (W6 * 16) % LINE_WORDS;
  localparam logic [3:0] WGT [8] = '{4'(W0), 4'(W1), 4'(W2), 4'(W3),
                                     4'(W4), 4'(W5), 4'(W6), 4'(W7)};
  // Reciprocal for the final reduction of an 11-bit sum
  localparam int RSH = 20;
  localparam logic [19:0] RECIP = 20'(((1 << RSH) + LINE_WORDS - 1) / LINE_WORDS);

  logic [10:0] sum;
  logic [30:0] prod;
  logic [10:0] quo;
  logic [10:0] rem;
  logic [3:0]  pos;

  // Fold nibbles by their weights, then one reciprocal multiply
  always_comb begin
    sum = 11'(phase_i);
    for (int k = 0; k < 8; k++) begin
      sum = sum + 11'(8'(offset_i[4*k +: 4]) * 8'(WGT[k]));
    end
    prod = 31'(sum) * 31'(RECIP);
    quo  = prod[RSH +: 11];
    rem  = sum - 11'(quo * 11'(LINE_WORDS));
    pos  = rem[3:0];
    head_o = (pos == 4'd0) ? 4'd0 : 4'(LINE_WORDS) - pos;
  end

endmodule

// ===== rtl/rswc_fifo.sv =====
// Two-entry queue between the front and back ends.
// Depends on rswc_pkg.
module rswc_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rswc_pkg::entry_t din_i,
  output logic             full_o,
  input  logic             pop_i,
  output rswc_pkg::entry_t dout_o,
  output logic             empty_o
);
  import rswc_pkg::*;

  entry_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign dout_o  = mem_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= din_i;
  end

endmodule

// ===== rtl/rswc_front.sv =====
// Front end: accepts command beats, extracts the bucket, precomputes head words.
// Depends on rswc_pkg and rswc_head.
module rswc_front #(
  parameter int DIGIT_BITS = 12,
  parameter int LINE_WORDS = 16
) (
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 command_i,
  input  logic [rswc_pkg::KEY_W-1:0] key_value_i,
  input  logic [rswc_pkg::IDX_W-1:0] bucket_index_i,
  input  logic [rswc_pkg::KEY_W-1:0] start_offset_i,
  input  logic [4:0]                 digit_shift_i,
  input  logic [3:0]                 base_phase_i,
  input  logic                       clearing_i,
  output logic                       push_o,
  output rswc_pkg::entry_t           entry_o,
  input  logic                       full_i
);
  import rswc_pkg::*;

  logic [KEY_W-1:0]     shifted;
  logic [BKT_W_MAX-1:0] idx_ext;
  logic [CNT_W_MAX-1:0] head;
  cmd_e                 cmd;

  rswc_head #(.LINE_WORDS(LINE_WORDS)) u_head (
    .offset_i (start_offset_i),
    .phase_i  (base_phase_i),
    .head_o   (head)
  );

  assign in_ready_o = !full_i && !clearing_i;
  assign push_o     = in_valid_i && in_ready_o;

  // Classify the beat
  always_comb begin
    cmd     = cmd_e'(command_i);
    shifted = key_value_i >> digit_shift_i;
    idx_ext = BKT_W_MAX'(bucket_index_i);
    entry_o.cmd  = cmd;
    entry_o.head = head;
    if (cmd == CMD_KEY) begin
      entry_o.bucket = BKT_W_MAX'(shifted[DIGIT_BITS-1:0]);
      entry_o.data   = key_value_i;
    end else begin
      entry_o.bucket = BKT_W_MAX'(idx_ext[DIGIT_BITS-1:0]);
      entry_o.data   = start_offset_i;
    end
  end

endmodule

// ===== rtl/rswc_back.sv =====
// Back end: bucket state memories, line buffers and the write sequencer.
// Depends on rswc_pkg and rswc_head.
module rswc_back #(
  parameter int DIGIT_BITS = 12,
  parameter int LINE_WORDS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rswc_pkg::entry_t           entry_i,
  input  logic                       empty_i,
  output logic                       pop_o,
  input  logic [3:0]                 base_phase_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rswc_pkg::KEY_W-1:0] write_address_o,
  output logic [rswc_pkg::KEY_W-1:0] write_data_o,
  output logic                       full_line_o,
  output logic                       last_word_o,
  output rswc_pkg::back_stat_t       stat_o
);
  import rswc_pkg::*;

  localparam int CW     = $clog2(LINE_WORDS);
  localparam int NB     = 1 << DIGIT_BITS;
  localparam int LB_AW  = DIGIT_BITS + CW;
  localparam int MW     = 2 * CW;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_BRD  = 3'd3;
  localparam logic [2:0] ST_BWR  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [KEY_W-1:0] off_mem  [NB];
  logic [MW-1:0]    meta_mem [NB];
  logic [KEY_W-1:0] lb_mem   [1 << LB_AW];

  logic [2:0]            state_q, state_d;
  logic [DIGIT_BITS-1:0] clr_q, clr_d;
  entry_t                cur_q, cur_d;
  logic [KEY_W-1:0]      off_rd_q, lb_rd_q;
  logic [MW-1:0]         meta_rd_q;
  logic [KEY_W-1:0]      base_q, base_d, new_off_q, new_off_d;
  logic [CW-1:0]         j_q, j_d;
  logic [CW:0]           n_q, n_d;
  logic                  full_q, full_d;
  logic                  out_valid_q, out_valid_d;
  logic [KEY_W-1:0]      out_addr_q, out_data_q;
  logic                  out_full_q, out_last_q;

  logic                  out_load, out_free;
  logic [KEY_W-1:0]      out_addr, out_data;
  logic                  out_full, out_last;
  logic                  off_we, meta_we, lb_we, lb_re;
  logic [DIGIT_BITS-1:0] rd_bkt, bkt, meta_wa;
  logic [KEY_W-1:0]      off_wd;
  logic [MW-1:0]         meta_wd;
  logic [LB_AW-1:0]      lb_wa, lb_ra;
  logic [CW-1:0]         fill, head;
  logic [CNT_W_MAX-1:0]  fin_head;
  logic                  burst_last;

  rswc_head #(.LINE_WORDS(LINE_WORDS)) u_head (
    .offset_i (new_off_q),
    .phase_i  (base_phase_i),
    .head_o   (fin_head)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign rd_bkt     = entry_i.bucket[DIGIT_BITS-1:0];
  assign bkt        = cur_q.bucket[DIGIT_BITS-1:0];
  assign fill       = meta_rd_q[MW-1:CW];
  assign head       = meta_rd_q[CW-1:0];
  assign lb_ra      = {bkt, j_q};
  assign burst_last = ((CW+1)'(j_q) + (CW+1)'(1)) == n_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    base_d      = base_q;
    new_off_d   = new_off_q;
    j_d         = j_q;
    n_d         = n_q;
    full_d      = full_q;
    pop_o       = 1'b0;
    off_we      = 1'b0;
    off_wd      = off_rd_q;
    meta_we     = 1'b0;
    meta_wa     = bkt;
    meta_wd     = '0;
    lb_we       = 1'b0;
    lb_wa       = {bkt, fill};
    lb_re       = 1'b0;
    out_load    = 1'b0;
    out_addr    = off_rd_q;
    out_data    = cur_q.data;
    out_full    = 1'b0;
    out_last    = 1'b1;
    unique case (state_q)
      ST_CLR: begin
        meta_we = 1'b1;
        meta_wa = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cur_d   = entry_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_d = ST_IDLE;
          unique case (cur_q.cmd)
            CMD_LOAD: begin
              off_we  = 1'b1;
              off_wd  = cur_q.data;
              meta_we = 1'b1;
              meta_wd = {CW'(0), cur_q.head[CW-1:0]};
            end
            CMD_KEY: begin
              meta_we = 1'b1;
              if (head != '0) begin
                // direct head write
                out_load = 1'b1;
                off_we   = 1'b1;
                off_wd   = off_rd_q + KEY_W'(1);
                meta_wd  = {fill, head - 1'b1};
              end else begin
                lb_we = 1'b1;
                if ((CW+1)'(fill) == (CW+1)'(LINE_WORDS - 1)) begin
                  off_we  = 1'b1;
                  off_wd  = off_rd_q + KEY_W'(LINE_WORDS);
                  meta_wd = {CW'(0), head};
                  base_d  = off_rd_q;
                  n_d     = (CW+1)'(LINE_WORDS);
                  j_d     = '0;
                  full_d  = 1'b1;
                  state_d = ST_BRD;
                end else begin
                  meta_wd = {fill + 1'b1, head};
                end
              end
            end
            CMD_FLUSH: begin
              base_d    = off_rd_q;
              new_off_d = off_rd_q + KEY_W'(fill);
              n_d       = (CW+1)'(fill);
              j_d       = '0;
              full_d    = 1'b0;
              state_d   = (fill == '0) ? ST_FIN : ST_BRD;
            end
            CMD_IGNORE: begin
              state_d = ST_IDLE;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_BRD: begin
        lb_re   = 1'b1;
        state_d = ST_BWR;
      end
      ST_BWR: begin
        if (out_free) begin
          out_load = 1'b1;
          out_addr = base_q + KEY_W'(j_q);
          out_data = lb_rd_q;
          out_full = full_q;
          out_last = burst_last;
          j_d      = j_q + 1'b1;
          if (burst_last) state_d = full_q ? ST_IDLE : ST_FIN;
          else            state_d = ST_BRD;
        end
      end
      ST_FIN: begin
        off_we  = 1'b1;
        off_wd  = new_off_q;
        meta_we = 1'b1;
        meta_wd = {CW'(0), fin_head[CW-1:0]};
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || out_load;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    base_q    <= base_d;
    new_off_q <= new_off_d;
    j_q       <= j_d;
    n_q       <= n_d;
    full_q    <= full_d;
    if (out_load) begin
      out_addr_q <= out_addr;
      out_data_q <= out_data;
      out_full_q <= out_full;
      out_last_q <= out_last;
    end
  end

  // Bucket offset memory
  always_ff @(posedge clk_i) begin
    if (off_we) off_mem[bkt] <= off_wd;
    if (pop_o)  off_rd_q <= off_mem[rd_bkt];
  end

  // Fill count and head word memory
  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (pop_o)   meta_rd_q <= meta_mem[rd_bkt];
  end

  // Line buffer memory
  always_ff @(posedge clk_i) begin
    if (lb_we) lb_mem[lb_wa] <= cur_q.data;
    if (lb_re) lb_rd_q <= lb_mem[lb_ra];
  end

  assign out_valid_o     = out_valid_q;
  assign write_address_o = out_addr_q;
  assign write_data_o    = out_data_q;
  assign full_line_o     = out_full_q;
  assign last_word_o     = out_last_q;
  assign stat_o.clearing = (state_q == ST_CLR);
  assign stat_o.idle     = (state_q == ST_IDLE);

endmodule

// ===== rtl/radix_scatter_write_combining.sv =====
// Radix-sort scatter stage with per-bucket write-combining line buffers.
// After reset the block clears its per-bucket fill and head counts, one bucket
// per cycle, and accepts no command meanwhile. Commands enter a two-entry
// queue; the back end then handles one command at a time: a load, a buffered
// key or a direct head write is a queue pop with bucket state read, then an
// update once the output register is free, and a line or flush burst reads each
// word from the line buffer's single read port, then loads it into the output register.
// A flush ends in a final state that stores the new offset and head words.
// Output beats can stall without blocking the queue from filling.
// Depends on rswc_pkg, rswc_front, rswc_fifo, rswc_back and the macros header.
module radix_scatter_write_combining #(
  parameter int DIGIT_BITS = 12,
  parameter int LINE_WORDS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [rswc_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 command_i,
  input  logic [rswc_pkg::KEY_W-1:0] key_value_i,
  input  logic [rswc_pkg::IDX_W-1:0] bucket_index_i,
  input  logic [rswc_pkg::KEY_W-1:0] start_offset_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rswc_pkg::KEY_W-1:0] write_address_o,
  output logic [rswc_pkg::KEY_W-1:0] write_data_o,
  output logic                       full_line_o,
  output logic                       last_word_o
);
  import rswc_pkg::*;
  `include "radix_scatter_write_combining_macros.svh"

  logic [4:0] digit_shift_q;
  logic [3:0] base_phase_q;
  logic       push, pop, full, empty;
  entry_t     push_entry, pop_entry;
  back_stat_t stat;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_shift_q <= 5'd20;
      base_phase_q  <= 4'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DIGIT_SHIFT: digit_shift_q <= cfg_data_i;
        CFG_BASE_PHASE:  base_phase_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  rswc_front #(.DIGIT_BITS(DIGIT_BITS), .LINE_WORDS(LINE_WORDS)) u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .key_value_i    (key_value_i),
    .bucket_index_i (bucket_index_i),
    .start_offset_i (start_offset_i),
    .digit_shift_i  (digit_shift_q),
    .base_phase_i   (base_phase_q),
    .clearing_i     (stat.clearing),
    .push_o         (push),
    .entry_o        (push_entry),
    .full_i         (full)
  );

  rswc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .dout_o  (pop_entry),
    .empty_o (empty)
  );

  rswc_back #(.DIGIT_BITS(DIGIT_BITS), .LINE_WORDS(LINE_WORDS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .entry_i         (pop_entry),
    .empty_i         (empty),
    .pop_o           (pop),
    .base_phase_i    (base_phase_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .full_line_o     (full_line_o),
    .last_word_o     (last_word_o),
    .stat_o          (stat)
  );

  // Checks
  `RSWC_ASSERT_IMPL(a_no_accept_clearing, in_ready_o, !stat.clearing, "accept during clear")
  `RSWC_ASSERT_IMPL(a_no_out_clearing, stat.clearing, !out_valid_o, "output during clear")
  `RSWC_ASSERT_IMPL(a_flush_mid_busy, out_valid_o && !full_line_o && !last_word_o, !stat.idle, "partial burst beat with idle back end")
  `RSWC_ASSERT_NEXT(a_clear_leaves_empty, $fell(stat.clearing), !out_valid_o, "output right after clear")

endmodule

// ===== test/radix_scatter_write_combining_tb.sv =====
// Self-checking bench for the radix scatter write-combining stage.
// Depends on rswc_pkg and the radix_scatter_write_combining top level.
module radix_scatter_write_combining_tb;
  import rswc_pkg::*;

  localparam int NBKT = 4096;
  localparam int LW   = 16;

  // One expected output beat
  typedef struct {
    logic [31:0] addr;
    logic [31:0] data;
    logic        full;
    logic        last;
  } wr_beat_t;

  // Scatter predictor and queue of pending write beats
  class scatter_scoreboard;
    logic [31:0] offs [NBKT];
    logic [3:0]  fill [NBKT];
    logic [3:0]  head [NBKT];
    logic [31:0] line [NBKT*LW];
    logic [4:0]  shift_r;
    logic [3:0]  phase_r;
    wr_beat_t    pending [$];
    int          errors;

    function new();
      shift_r = 5'd20;
      phase_r = 4'd0;
      errors  = 0;
      for (int i = 0; i < NBKT; i++) begin
        offs[i] = '0;
        fill[i] = '0;
        head[i] = '0;
      end
    endfunction

    function logic [3:0] head_words(logic [31:0] off);
      logic [3:0] pos;
      pos = phase_r + off[3:0];
      return 4'd0 - pos;
    endfunction

    function void push(logic [31:0] a, logic [31:0] d, logic f, logic l);
      wr_beat_t b;
      b.addr = a; b.data = d; b.full = f; b.last = l;
      pending.push_back(b);
    endfunction

    function void note_input(cmd_e cmd, logic [31:0] key, logic [11:0] bi,
                             logic [31:0] so);
      int b;
      int f;
      case (cmd)
        CMD_LOAD: begin
          offs[bi] = so;
          fill[bi] = '0;
          head[bi] = head_words(so);
        end
        CMD_KEY: begin
          b = (key >> shift_r) & (NBKT - 1);
          if (head[b] != 0) begin
            push(offs[b], key, 1'b0, 1'b1);
            offs[b] = offs[b] + 1;
            head[b] = head[b] - 1;
          end else begin
            f = fill[b];
            line[b*LW+f] = key;
            if (f == LW - 1) begin
              for (int j = 0; j < LW; j++)
                push(offs[b] + j, line[b*LW+j], 1'b1, j == LW - 1);
              offs[b] = offs[b] + LW;
              fill[b] = '0;
            end else begin
              fill[b] = f + 1;
            end
          end
        end
        CMD_FLUSH: begin
          f = fill[bi];
          for (int j = 0; j < f; j++)
            push(offs[bi] + j, line[bi*LW+j], 1'b0, j == f - 1);
          offs[bi] = offs[bi] + f;
          fill[bi] = '0;
          head[bi] = head_words(offs[bi]);
        end
        default: ;
      endcase
    endfunction

    function void check_beat(logic [31:0] a, logic [31:0] d, logic f, logic l);
      wr_beat_t e;
      if (pending.size() == 0) begin
        $error("unexpected write beat addr=%h data=%h", a, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a !== e.addr) begin
        $error("write_address exp=%h got=%h", e.addr, a); errors++;
      end
      if (d !== e.data) begin
        $error("write_data exp=%h got=%h", e.data, d); errors++;
      end
      if (f !== e.full) begin
        $error("full_line exp=%b got=%b", e.full, f); errors++;
      end
      if (l !== e.last) begin
        $error("last_word exp=%b got=%b", e.last, l); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [4:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = '0;
  logic [31:0] key_value_i = '0;
  logic [11:0] bucket_index_i = '0;
  logic [31:0] start_offset_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] write_address_o;
  logic [31:0] write_data_o;
  logic        full_line_o;
  logic        last_word_o;

  scatter_scoreboard sb = new();
  bit  calm;           // no idling on either side while set
  bit  loaded [NBKT];
  int  live_bkts [$];  // loaded buckets, used for key generation

  radix_scatter_write_combining u_top (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver: random stalls, checks each accepted beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_beat(write_address_o, write_data_o, full_line_o, last_word_o);
    out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 10);
  end

  // Present one command and hold it until accepted; valid stays up afterwards
  // so that beats can follow back to back
  task automatic send_cmd(cmd_e cmd, logic [31:0] key, logic [11:0] bi,
                          logic [31:0] so);
    if (!calm && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 10);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    key_value_i    <= key;
    bucket_index_i <= bi;
    start_offset_i <= so;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(cmd, key, bi, so);
  endtask

  task automatic load_bkt(logic [11:0] bi, logic [31:0] so);
    send_cmd(CMD_LOAD, '0, bi, so);
    if (!loaded[bi]) live_bkts.push_back(bi);
    loaded[bi] = 1'b1;
  endtask

  // Key that lands in the given bucket under the current shift, when the bucket fits in the key bits above the shift
  function automatic logic [31:0] key_for(int bi);
    logic [63:0] k;
    logic [31:0] r;
    r = $urandom();
    k = {32'd0, r} & ~(64'hFFF << sb.shift_r);
    k = k | (64'(bi) << sb.shift_r);
    return k[31:0];
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [4:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DIGIT_SHIFT) sb.shift_r = val;
    else sb.phase_r = val[3:0];
  endtask

  // Random phase: mostly keys into loaded buckets, some loads, flushes and ignored commands
  task automatic random_phase(int n);
    int b;
    int r;
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 3 && i < n / 2);
      b = live_bkts[$urandom_range(live_bkts.size() - 1)];
      r = $urandom_range(99);
      if (r < 78) begin
        send_cmd(CMD_KEY, key_for(b), $urandom(), $urandom());
      end else if (r < 86) begin
        send_cmd(CMD_FLUSH, $urandom(), b, $urandom());
      end else if (r < 94) begin
        if ($urandom_range(1)) load_bkt(b, $urandom());
        else load_bkt($urandom_range(NBKT - 1), $urandom());
      end else begin
        send_cmd(CMD_IGNORE, $urandom(), $urandom(), $urandom());
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    calm = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: head writes, a full line, flushes, reload, ignored command
    write_cfg(CFG_DIGIT_SHIFT, 5'd0);
    write_cfg(CFG_BASE_PHASE, 4'd0);
    load_bkt(12'd0, 32'hFFFF_FFFE);        // two head words, then address wrap
    load_bkt(12'hFFF, 32'h0000_0010);      // aligned: no head words
    send_cmd(CMD_KEY, 32'h0000_0000, '0, '0);
    send_cmd(CMD_KEY, 32'hFFFF_F000, '0, '0);
    for (int j = 0; j < 16; j++)
      send_cmd(CMD_KEY, {20'hABCDE + j[19:0], 12'hFFF}, '0, '0);
    send_cmd(CMD_KEY, 32'h1234_5000, '0, '0);   // buffered in bucket 0
    send_cmd(CMD_FLUSH, '0, 12'd0, '0);
    send_cmd(CMD_FLUSH, '0, 12'd0, '0);         // empty flush
    send_cmd(CMD_KEY, 32'hFFFF_FFFF, '0, '0);
    load_bkt(12'hFFF, 32'h0000_0003);           // drops the buffered word
    send_cmd(CMD_IGNORE, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF);
    drain();

    // Random phases over several register settings
    write_cfg(CFG_DIGIT_SHIFT, 5'd31);
    write_cfg(CFG_BASE_PHASE, 4'd15);
    load_bkt(12'd1, $urandom());
    random_phase(15);
    // hold off until everything is out
    drain();
    write_cfg(CFG_DIGIT_SHIFT, 5'd28);
    write_cfg(CFG_BASE_PHASE, 4'd7);
    // every digit reachable under this shift gets a start offset
    for (int i = 0; i < 16; i++) load_bkt(12'(i), $urandom());
    random_phase(25);
    drain();
    write_cfg(CFG_DIGIT_SHIFT, 5'd20);
    write_cfg(CFG_BASE_PHASE, 4'd0);
    for (int i = 0; i < 3; i++) load_bkt($urandom_range(NBKT - 1), $urandom());
    random_phase(30);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end
endmodule

// ===== radix_scatter_write_combining.f =====
+incdir+rtl
rtl/rswc_pkg.sv
rtl/rswc_head.sv
rtl/rswc_fifo.sv
rtl/rswc_front.sv
rtl/rswc_back.sv
rtl/radix_scatter_write_combining.sv
test/radix_scatter_write_combining_tb.sv
